@@ src/assert_macros.svh @@
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BRE_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BRE_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ src/bre_pkg.sv @@
// types and constants of the bier replication engine
package bre_pkg;

  localparam int ROUTE_DEPTH = 64;
  localparam int RA_W        = 6;
  localparam int FULL_BITS   = 64;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID = 1'b1;

  localparam logic [1:0] OP_FORWARD = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_DELETE  = 2'd2;

  localparam logic [2:0] KIND_LOCAL    = 3'd0;
  localparam logic [2:0] KIND_FORWARD  = 3'd1;
  localparam logic [2:0] KIND_NONE     = 3'd2;
  localparam logic [2:0] KIND_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_UPDATED  = 3'd4;

  typedef struct packed {
    logic [1:0]           operation;
    logic [19:0]          packet_table_id;
    logic [FULL_BITS-1:0] packet_bits;
    logic [7:0]           packet_ttl;
    logic [6:0]           route_id;
    logic [FULL_BITS-1:0] route_mask;
    logic [7:0]           route_port;
  } bre_in_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [7:0]           egress_port;
    logic [6:0]           neighbor_id;
    logic [FULL_BITS-1:0] copy_bits;
    logic [7:0]           copy_ttl;
    logic                 last;
  } bre_out_t;

  // route table write request
  typedef struct packed {
    logic                 we;
    logic                 set;
    logic [RA_W-1:0]      addr;
    logic [FULL_BITS-1:0] mask;
    logic [7:0]           port;
  } bre_tbl_wr_t;

endpackage

@@ src/bier_replication_engine_top.sv @@
// top level of the bier replication engine: sequencer, config and result registers
//
// Input channel in_valid/in_ready/in_data carries forward items and route updates.
// Result channel out_valid/out_ready/out_data returns one or more results per
// forward or route item, the final one flagged by last. Config port
// cfg_we/cfg_index/cfg_wdata writes table_id (index 0) and local_bfr_id (index 1).
// The user must write only while idle; the block does not enforce it. A route add
// or delete goes to the hold register and then the output register; a table id
// mismatch likewise. A forward item visits set bitstring bits lowest first: state
// FIND does the lowest set bit search and issues the route table read, then state
// STEP decides and emits, one route table read per visit. in_ready is
// high only between items. Results are held one deep so the last flag can be
// placed; a stalled receiver stops the sequencer until the output register frees.
// Synchronous reset clears all routes, both config registers and the channels.
module bier_replication_engine_top import bre_pkg::*; #(
  parameter int BITSTRING_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bre_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bre_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

`include "assert_macros.svh"

  localparam int B  = BITSTRING_BITS;
  localparam int KW = $clog2(BITSTRING_BITS);

  typedef enum logic [1:0] {ST_IDLE, ST_FIND, ST_STEP, ST_FIN} state_t;

  state_t      state_r, state_nxt;
  logic [19:0] table_id_r;
  logic [15:0] local_id_r;
  logic [B-1:0] bs_r, bs_nxt;
  logic [B-1:0] bit_r, bit_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  bre_out_t    hold_r, hold_nxt;
  logic        hold_vld_r, hold_vld_nxt;
  bre_out_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic          in_fire, out_free;
  logic [B-1:0]  find_onehot;
  logic [KW-1:0] find_idx;
  bre_tbl_wr_t   tbl_wr;
  logic          rd_en;
  logic          rd_valid;
  logic [B-1:0]  rd_fbm;
  logic [7:0]    rd_port;
  logic          local_hit, step_emit, step_go;
  logic [B-1:0]  clr;
  bre_out_t      step_res;
  logic          tid_miss, miss_held, copy_out;

  bre_lsb_find #(.WIDTH(B)) u_find (
    .bits   (bs_r),
    .onehot (find_onehot),
    .index  (find_idx)
  );

  bre_route_table #(.FBM_BITS(B)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_en    (rd_en),
    .rd_addr  (RA_W'(k_nxt)),
    .rd_valid (rd_valid),
    .rd_fbm   (rd_fbm),
    .rd_port  (rd_port)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_id_r <= '0;
      local_id_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TABLE_ID: table_id_r <= cfg_wdata;
        REG_LOCAL_ID: local_id_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // decision for the bit being served
  always_comb begin
    local_hit = (local_id_r == 16'(k_r) + 16'd1);
    step_res  = '0;
    step_emit = 1'b0;
    clr       = bit_r;
    if (local_hit) begin
      step_emit     = 1'b1;
      step_res.kind = KIND_LOCAL;
    end else if (rd_valid) begin
      step_emit            = 1'b1;
      step_res.kind        = KIND_FORWARD;
      step_res.egress_port = rd_port;
      step_res.neighbor_id = 7'(k_r) + 7'd1;
      step_res.copy_bits   = FULL_BITS'(bs_r & rd_fbm);
      step_res.copy_ttl    = ttl_r;
      clr                  = bit_r | rd_fbm;
    end
    step_go = !(step_emit && hold_vld_r && !out_free);
  end

  always_comb begin
    state_nxt     = state_r;
    bs_nxt        = bs_r;
    bit_nxt       = bit_r;
    k_nxt         = k_r;
    ttl_nxt       = ttl_r;
    hold_nxt      = hold_r;
    hold_vld_nxt  = hold_vld_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    tbl_wr        = '0;
    rd_en         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.operation) inside
            OP_FORWARD: begin
              if (in_data.packet_table_id != table_id_r) begin
                hold_nxt      = '0;
                hold_nxt.kind = KIND_MISMATCH;
                hold_vld_nxt  = 1'b1;
                state_nxt     = ST_FIN;
              end else begin
                bs_nxt       = in_data.packet_bits[B-1:0];
                ttl_nxt      = in_data.packet_ttl - 8'd1;
                hold_vld_nxt = 1'b0;
                state_nxt    = (in_data.packet_bits[B-1:0] == '0) ? ST_FIN : ST_FIND;
              end
            end
            OP_ADD, OP_DELETE: begin
              tbl_wr.we     = (in_data.route_id >= 7'd1) &&
                              (in_data.route_id <= 7'(ROUTE_DEPTH));
              tbl_wr.set    = (in_data.operation == OP_ADD);
              tbl_wr.addr   = RA_W'(in_data.route_id - 7'd1);
              tbl_wr.mask   = in_data.route_mask;
              tbl_wr.port   = in_data.route_port;
              hold_nxt      = '0;
              hold_nxt.kind = KIND_UPDATED;
              hold_vld_nxt  = 1'b1;
              state_nxt     = ST_FIN;
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        k_nxt     = find_idx;
        bit_nxt   = find_onehot;
        rd_en     = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (step_go) begin
          if (step_emit) begin
            // previous result is not the last one, release it
            if (hold_vld_r) begin
              out_nxt       = hold_r;
              out_nxt.last  = 1'b0;
              out_valid_nxt = 1'b1;
            end
            hold_nxt     = step_res;
            hold_vld_nxt = 1'b1;
          end
          bs_nxt    = bs_r & ~clr;
          state_nxt = ((bs_r & ~clr) == '0) ? ST_FIN : ST_FIND;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          if (hold_vld_r) begin
            out_nxt = hold_r;
          end else begin
            out_nxt      = '0;
            out_nxt.kind = KIND_NONE;
          end
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          hold_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bs_r   <= bs_nxt;
    bit_r  <= bit_nxt;
    k_r    <= k_nxt;
    ttl_r  <= ttl_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign tid_miss  = in_fire && (in_data.operation == OP_FORWARD) &&
                     (in_data.packet_table_id != table_id_r);
  assign miss_held = (state_r == ST_FIN) && (hold_r.kind == KIND_MISMATCH);
  assign copy_out  = out_valid_r && (out_r.kind == KIND_FORWARD);

  `BRE_ASSERT_NXT(a_mismatch_result, clk, rst_n, tid_miss, miss_held)
  `BRE_ASSERT_IMP(a_find_has_bits, clk, rst_n, state_r == ST_FIND, bs_r != '0)
  `BRE_ASSERT_IMP(a_step_consumes, clk, rst_n, state_r == ST_STEP && step_go, ~|(bs_nxt & bit_r))
  `BRE_ASSERT_IMP(a_copy_has_neighbor, clk, rst_n, copy_out, out_r.neighbor_id != 7'd0)

endmodule

@@ src/bre_lsb_find.sv @@
// lowest set bit finder: one-hot isolate and binary index
module bre_lsb_find import bre_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]         bits,
  output logic [WIDTH-1:0]         onehot,
  output logic [$clog2(WIDTH)-1:0] index
);

  localparam int IW = $clog2(WIDTH);

  // two's complement trick keeps only the lowest one
  assign onehot = bits & (~bits + WIDTH'(1));

  always_comb begin
    index = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (onehot[i]) begin
        index = index | IW'(i);
      end
    end
  end

endmodule

@@ src/bre_route_table.sv @@
// route table: valid flags, forwarding bit masks and egress ports
module bre_route_table import bre_pkg::*; #(
  parameter int FBM_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bre_tbl_wr_t         wr,
  input  logic                rd_en,
  input  logic [RA_W-1:0]     rd_addr,
  output logic                rd_valid,
  output logic [FBM_BITS-1:0] rd_fbm,
  output logic [7:0]          rd_port
);

  logic [ROUTE_DEPTH-1:0] valid_r;
  logic [FBM_BITS-1:0]    fbm_mem [ROUTE_DEPTH];
  logic [7:0]             port_mem [ROUTE_DEPTH];
  logic                   rd_valid_r;
  logic [FBM_BITS-1:0]    rd_fbm_r;
  logic [7:0]             rd_port_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= wr.set;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.set) begin
      fbm_mem[wr.addr]  <= wr.mask[FBM_BITS-1:0];
      port_mem[wr.addr] <= wr.port;
    end
  end

  // registered read, holds until the next read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
      rd_fbm_r   <= fbm_mem[rd_addr];
      rd_port_r  <= port_mem[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_fbm   = rd_fbm_r;
  assign rd_port  = rd_port_r;

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the bier replication engine top level
`timescale 1ns / 1ps

module tb;
  import bre_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 44;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bre_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bre_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bier_replication_engine_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow of the block's configuration and route table
  logic [19:0] exp_table_id = '0;
  logic [15:0] exp_local_id = '0;
  logic tbl_valid [ROUTE_DEPTH];
  logic [FULL_BITS-1:0] tbl_fbm [ROUTE_DEPTH];
  logic [7:0] tbl_port [ROUTE_DEPTH];

  bre_in_t pending_items[$];
  bre_out_t expected_results[$];
  int items_sent = 0;
  int items_taken = 0;
  int errors = 0;

  bit in_acc = 1'b0;
  bit out_acc = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  initial begin
    for (int i = 0; i < ROUTE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_fbm[i] = '0;
      tbl_port[i] = '0;
    end
  end

  function automatic bre_out_t make_result(logic [2:0] kind, logic [7:0] port,
                                           logic [6:0] nb, logic [63:0] bits,
                                           logic [7:0] ttl);
    bre_out_t r;
    r.kind = kind;
    r.egress_port = port;
    r.neighbor_id = nb;
    r.copy_bits = bits;
    r.copy_ttl = ttl;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void predict_results(input bre_in_t it);
    bre_out_t batch[$];
    bre_out_t r;
    logic [63:0] bs;
    logic [63:0] fbm;
    logic [63:0] one_hot;
    logic [7:0] ttl;
    int k;
    if (it.operation == OP_ADD || it.operation == OP_DELETE) begin
      if (it.route_id >= 1 && it.route_id <= ROUTE_DEPTH) begin
        k = int'(it.route_id) - 1;
        if (it.operation == OP_ADD) begin
          tbl_valid[k] = 1'b1;
          tbl_fbm[k] = it.route_mask;
          tbl_port[k] = it.route_port;
        end else begin
          tbl_valid[k] = 1'b0;
        end
      end
      batch.push_back(make_result(KIND_UPDATED, '0, '0, '0, '0));
    end else if (it.operation == OP_FORWARD) begin
      if (it.packet_table_id != exp_table_id) begin
        batch.push_back(make_result(KIND_MISMATCH, '0, '0, '0, '0));
      end else begin
        bs = it.packet_bits;
        ttl = it.packet_ttl - 8'd1;
        while (bs != '0) begin
          k = 0;
          while (!bs[k]) k++;
          one_hot = 64'd1 << k;
          if (int'(exp_local_id) == k + 1) begin
            batch.push_back(make_result(KIND_LOCAL, '0, '0, '0, '0));
            bs &= ~one_hot;
          end else if (tbl_valid[k]) begin
            fbm = tbl_fbm[k];
            batch.push_back(make_result(KIND_FORWARD, tbl_port[k], 7'(k + 1), bs & fbm, ttl));
            bs &= ~(fbm | one_hot);
          end else begin
            bs &= ~one_hot;
          end
        end
        if (batch.size() == 0) batch.push_back(make_result(KIND_NONE, '0, '0, '0, '0));
      end
    end
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input bre_out_t got);
    bre_out_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with none expected, expected nothing actual %0h", $time, got);
      errors++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 64'(want.kind), 64'(got.kind));
      check_field("egress_port", 64'(want.egress_port), 64'(got.egress_port));
      check_field("neighbor_id", 64'(want.neighbor_id), 64'(got.neighbor_id));
      check_field("copy_bits", want.copy_bits, got.copy_bits);
      check_field("copy_ttl", 64'(want.copy_ttl), 64'(got.copy_ttl));
      check_field("last", 64'(want.last), 64'(got.last));
    end
  endtask

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    in_acc = 1'b0;
    out_acc = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_acc = 1'b1;
        items_taken++;
        predict_results(in_data);
      end
      if (out_valid && out_ready) begin
        out_acc = 1'b1;
        check_result(out_data);
      end
    end
  end

  // driver: offers pending items, random gap after each transaction
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        if ($urandom_range(29) == 0) tx_calm = !tx_calm;
        tx_wait = tx_calm ? 0 : $urandom_range(12);
      end
      if (in_valid && !in_acc) begin
        // hold the offered item
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each result, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (out_acc) begin
        if ($urandom_range(39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(12);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic bre_in_t forward_item(logic [19:0] tid, logic [63:0] bits, logic [7:0] ttl);
    bre_in_t it;
    it.operation = OP_FORWARD;
    it.packet_table_id = tid;
    it.packet_bits = bits;
    it.packet_ttl = ttl;
    it.route_id = 7'($urandom);
    it.route_mask = {$urandom, $urandom};
    it.route_port = 8'($urandom);
    return it;
  endfunction

  function automatic bre_in_t route_item(logic [1:0] op, logic [6:0] id, logic [63:0] mask,
                                         logic [7:0] port);
    bre_in_t it;
    it.operation = op;
    it.packet_table_id = 20'($urandom);
    it.packet_bits = {$urandom, $urandom};
    it.packet_ttl = 8'($urandom);
    it.route_id = id;
    it.route_mask = mask;
    it.route_port = port;
    return it;
  endfunction

  function automatic bre_in_t unused_item();
    bre_in_t it;
    it = route_item(OP_UNUSED, 7'($urandom), {$urandom, $urandom}, 8'($urandom));
    return it;
  endfunction

  function automatic logic [63:0] rand_bits();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2, 3: begin
        v = '0;
        repeat ($urandom_range(1, 4)) v[$urandom_range(63)] = 1'b1;
      end
      4, 5: v = {$urandom, $urandom} & {$urandom, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [6:0] rand_route_id();
    if ($urandom_range(7) != 0) return 7'($urandom_range(1, ROUTE_DEPTH));
    if ($urandom_range(1) == 0) return 7'd0;
    return 7'($urandom_range(65, 127));
  endfunction

  task automatic send(input bre_in_t it);
    pending_items.push_back(it);
    items_sent++;
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send(forward_item(exp_table_id, rand_bits(), 8'($urandom)));
    else if (pick < 62)
      send(forward_item(20'($urandom), rand_bits(), 8'($urandom)));
    else if (pick < 88)
      send(route_item(OP_ADD, rand_route_id(), rand_bits(), 8'($urandom)));
    else if (pick < 97)
      send(route_item(OP_DELETE, rand_route_id(), rand_bits(), 8'($urandom)));
    else
      send(unused_item());
  endtask

  // every transaction taken and answered, then let an ignored item finish
  task automatic wait_drain();
    while (items_taken != items_sent || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TABLE_ID) exp_table_id = val;
    else if (idx == REG_LOCAL_ID) exp_local_id = val[15:0];
  endtask

  task automatic random_phase(input logic [19:0] tid, input logic [15:0] lid, input bit long_hold);
    wait_drain();
    write_reg(REG_TABLE_ID, tid);
    write_reg(REG_LOCAL_ID, 20'(lid));
    if (long_hold) hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_random();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: table id 0, no local id
    send(forward_item(20'h0, 64'h0, 8'h40));
    send(forward_item(20'hFFFFF, '1, 8'h00));
    send(forward_item(20'h0, '1, 8'h01));
    send(route_item(OP_ADD, 7'd1, '1, 8'hFF));
    send(route_item(OP_ADD, 7'd64, 64'h0, 8'h00));
    send(route_item(OP_ADD, 7'd0, '1, 8'h03));
    send(route_item(OP_DELETE, 7'd127, '1, 8'h55));
    send(forward_item(20'h0, '1, 8'h00));
    send(forward_item(20'h0, 64'h8000_0000_0000_0000, 8'hFF));
    send(unused_item());
    send(route_item(OP_DELETE, 7'd1, 64'h0, 8'h00));
    send(route_item(OP_ADD, 7'd2, 64'h0000_0000_0000_00F2, 8'h80));
    send(forward_item(20'h0, 64'h0000_0000_0000_00FF, 8'h10));

    wait_drain();
    write_reg(REG_TABLE_ID, 20'hFFFFF);
    write_reg(REG_LOCAL_ID, 20'd1);
    send(forward_item(20'hFFFFF, 64'h1, 8'h01));
    send(forward_item(20'hFFFFF, 64'h8000_0000_0000_0003, 8'h00));
    send(forward_item(20'h0, 64'h1, 8'h05));

    // local id on the top bit wins over its route
    wait_drain();
    write_reg(REG_LOCAL_ID, 20'd64);
    write_reg(REG_TABLE_ID, 20'h5A5A5);
    send(forward_item(20'h5A5A5, 64'h8000_0000_0000_0000, 8'h03));
    send(forward_item(20'h5A5A5, '1, 8'h09));

    wait_drain();
    write_reg(REG_LOCAL_ID, 20'hFFFF);
    send(forward_item(20'h5A5A5, 64'h8000_0000_0000_0000, 8'h07));

    random_phase(20'h0, 16'd0, 1'b0);
    random_phase(20'hFFFFF, 16'hFFFF, 1'b0);
    random_phase(20'($urandom), 16'($urandom_range(1, 64)), 1'b1);
    random_phase(20'($urandom), 16'd64, 1'b0);
    random_phase(20'($urandom), 16'($urandom), 1'b0);

    wait_drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
